// File: hdl/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
// Used by every module under hdl/; depends on nothing else.
package htfd_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int POS_W      = 3;
   localparam int OFFSET_W   = 11;
   localparam int TEMP_W     = 15;
   localparam int HUM_W      = 14;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - TEMP_W - HUM_W;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   // Byte positions within the six-byte read frame.
   localparam logic [POS_W-1:0] POS_TEMP_MSB = 3'd0;
   localparam logic [POS_W-1:0] POS_TEMP_LSB = 3'd1;
   localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
   localparam logic [POS_W-1:0] POS_HUM_MSB  = 3'd3;
   localparam logic [POS_W-1:0] POS_HUM_LSB  = 3'd4;
   localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;

   // Scaling: temperature = floor(17500*raw/2^16) - 4500, humidity = floor(10000*raw/2^16).
   localparam int TEMP_PROD_W = WORD_W + TEMP_W;
   localparam int HUM_PROD_W  = WORD_W + HUM_W;
   localparam logic [TEMP_PROD_W-1:0] TEMP_SCALE = 31'd17500;
   localparam logic [HUM_PROD_W-1:0]  HUM_SCALE  = 30'd10000;
   localparam logic signed [TEMP_W:0] TEMP_BIAS  = 16'sd4500;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [WORD_W-1:0] temp_word;
      logic [WORD_W-1:0] hum_word;
      logic              crc_ok;
   } job_type;

   // CRC-8, polynomial 0x31, MSB first, one byte folded in.
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// File: hdl/htfd_front.sv
// Front end of the frame decoder: tracks the byte position, runs the CRC and
// assembles the two words. Depends on htfd_pkg; pushes one job per full frame.
module htfd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [htfd_pkg::BYTE_W-1:0] byte_value,
   input  logic                        frame_start,
   input  logic                        queue_full,
   output logic                        push,
   output htfd_pkg::job_type           push_data
);

   logic [htfd_pkg::POS_W-1:0]  pos_ff, pos_in, pos_cur;
   logic [htfd_pkg::BYTE_W-1:0] crc_ff, crc_in, crc_cur;
   logic [htfd_pkg::WORD_W-1:0] tword_ff, tword_in;
   logic [htfd_pkg::WORD_W-1:0] hword_ff, hword_in;
   logic                        good1_ff, good1_in;
   logic                        accept;
   logic                        last_byte;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // A start mark restarts the frame on this very item.
   assign pos_cur = frame_start ? htfd_pkg::POS_TEMP_MSB : pos_ff;
   assign crc_cur = frame_start ? htfd_pkg::CRC_INIT : crc_ff;

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      tword_in  = tword_ff;
      hword_in  = hword_ff;
      good1_in  = good1_ff;
      last_byte = 1'b0;
      if (accept) begin
         unique case (pos_cur)
            htfd_pkg::POS_TEMP_MSB: begin
               crc_in   = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, byte_value);
               tword_in = {byte_value, tword_ff[htfd_pkg::BYTE_W-1:0]};
               pos_in   = htfd_pkg::POS_TEMP_LSB;
            end
            htfd_pkg::POS_TEMP_LSB: begin
               crc_in   = htfd_pkg::crc8_byte(crc_cur, byte_value);
               tword_in = {tword_ff[htfd_pkg::WORD_W-1:htfd_pkg::BYTE_W], byte_value};
               pos_in   = htfd_pkg::POS_TEMP_CRC;
            end
            htfd_pkg::POS_TEMP_CRC: begin
               good1_in = (crc_cur == byte_value);
               crc_in   = htfd_pkg::CRC_INIT;
               pos_in   = htfd_pkg::POS_HUM_MSB;
            end
            htfd_pkg::POS_HUM_MSB: begin
               crc_in   = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, byte_value);
               hword_in = {byte_value, hword_ff[htfd_pkg::BYTE_W-1:0]};
               pos_in   = htfd_pkg::POS_HUM_LSB;
            end
            htfd_pkg::POS_HUM_LSB: begin
               crc_in   = htfd_pkg::crc8_byte(crc_cur, byte_value);
               hword_in = {hword_ff[htfd_pkg::WORD_W-1:htfd_pkg::BYTE_W], byte_value};
               pos_in   = htfd_pkg::POS_HUM_CRC;
            end
            default: begin
               crc_in    = htfd_pkg::CRC_INIT;
               pos_in    = htfd_pkg::POS_TEMP_MSB;
               last_byte = 1'b1;
            end
         endcase
      end
   end

   assign push                = last_byte;
   assign push_data.temp_word = tword_ff;
   assign push_data.hum_word  = hword_ff;
   assign push_data.crc_ok    = good1_ff && (crc_cur == byte_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= htfd_pkg::POS_TEMP_MSB;
         crc_ff   <= htfd_pkg::CRC_INIT;
         tword_ff <= '0;
         hword_ff <= '0;
         good1_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         tword_ff <= tword_in;
         hword_ff <= hword_in;
         good1_ff <= good1_in;
      end
   end

endmodule

// File: hdl/htfd_queue.sv
// Short job queue between the decoder front end and the scaling back end.
// Depends on htfd_pkg for the job type and depth.
module htfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  htfd_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output htfd_pkg::job_type pop_data
);

   htfd_pkg::job_type          entries_ff [htfd_pkg::QUEUE_DEPTH];
   logic [htfd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [htfd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [htfd_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [htfd_pkg::QPTR_W-1:0] LAST_PTR = htfd_pkg::QPTR_W'(htfd_pkg::QUEUE_DEPTH - 1);
   localparam logic [htfd_pkg::QCNT_W-1:0] FULL_CNT = htfd_pkg::QCNT_W'(htfd_pkg::QUEUE_DEPTH);

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a write");
`endif

endmodule

// File: hdl/htfd_back.sv
// Back end of the frame decoder: scales the raw words to centi-units, applies
// the temperature offset and holds the result item. Depends on htfd_pkg.
module htfd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_valid,
   input  htfd_pkg::job_type                    job,
   output logic                                 job_pop,
   input  logic signed [htfd_pkg::OFFSET_W-1:0] temp_offset,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [htfd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser
);

   logic                              s1_valid_ff, s2_valid_ff;
   logic [htfd_pkg::TEMP_W-1:0]       s1_temp_ff, s1_temp_in;
   logic [htfd_pkg::HUM_W-1:0]        s1_hum_ff, s1_hum_in;
   logic                              s1_ok_ff;
   logic [htfd_pkg::TEMP_W-1:0]       s2_temp_ff, s2_temp_in;
   logic [htfd_pkg::HUM_W-1:0]        s2_hum_ff;
   logic                              s2_ok_ff;
   logic [htfd_pkg::TEMP_PROD_W-1:0]  temp_prod;
   logic [htfd_pkg::HUM_PROD_W-1:0]   hum_prod;
   logic signed [htfd_pkg::TEMP_W:0]  temp_sum;
   logic                              s2_load, s1_load;

   // Each stage moves when the one after it is empty or moving.
   assign s2_load = !s2_valid_ff || rsp_tready;
   assign s1_load = !s1_valid_ff || s2_load;
   assign job_pop = job_valid && s1_load;

   assign temp_prod  = htfd_pkg::TEMP_PROD_W'(job.temp_word) * htfd_pkg::TEMP_SCALE;
   assign hum_prod   = htfd_pkg::HUM_PROD_W'(job.hum_word) * htfd_pkg::HUM_SCALE;
   assign s1_temp_in = temp_prod[htfd_pkg::TEMP_PROD_W-1:htfd_pkg::WORD_W];
   assign s1_hum_in  = hum_prod[htfd_pkg::HUM_PROD_W-1:htfd_pkg::WORD_W];

   // The sum cannot leave the 15-bit signed range for any 11-bit offset.
   assign temp_sum = $signed({1'b0, s1_temp_ff}) - htfd_pkg::TEMP_BIAS
                   - $signed({{(htfd_pkg::TEMP_W + 1 - htfd_pkg::OFFSET_W)
                                {temp_offset[htfd_pkg::OFFSET_W-1]}}, temp_offset});
   assign s2_temp_in = temp_sum[htfd_pkg::TEMP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= job_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         s1_temp_ff <= s1_temp_in;
         s1_hum_ff  <= s1_hum_in;
         s1_ok_ff   <= job.crc_ok;
      end
      if (s2_load && s1_valid_ff) begin
         s2_temp_ff <= s2_temp_in;
         s2_hum_ff  <= s1_hum_ff;
         s2_ok_ff   <= s1_ok_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {{htfd_pkg::RSP_PAD_W{1'b0}}, s2_hum_ff, s2_temp_ff};
   assign rsp_tuser  = s2_ok_ff;

`ifndef NO_ASSERTIONS
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (!s1_valid_ff || !s2_valid_ff || rsp_tready))
      else $error("job taken with no room in the pipeline");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_tready) |=> s2_valid_ff && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_hum_ff < 14'd10000)
      else $error("scaled humidity out of range");
`endif

endmodule

// File: hdl/humidity_temp_frame_decoder.sv
// Top level of the temperature/humidity sensor frame decoder.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
//
// Usage:
//   req_*  : one received frame byte per item, tdata = byte, tuser = frame start.
//   rsp_*  : one result item per complete six-byte frame.
//   csr_*  : write of the signed temperature offset in hundredths of a degree;
//            write it only while no frame is in flight.
// Throughput is one byte per cycle while the two-entry job queue has room; the front
// end keeps accepting bytes then, also while a finished result waits at the output.
// The job of a finished frame is written into the queue, then registered in the multiply
// stage and in the offset stage, whose register drives the rsp_* outputs.
// A start mark on a byte drops any partial frame and restarts the CRC.
// When the receiver stalls, the result holds; the queue then fills and
// req_tready falls only when the queue is full.
// Reset (synchronous, active high) clears the byte position, CRC state, words,
// the queue and the pipeline, and sets the offset to zero.
module humidity_temp_frame_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [htfd_pkg::BYTE_W-1:0]          req_tdata,  // [7:0] byte_value
   input  logic                                 req_tuser,  // [0] frame_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [htfd_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [14:0] temperature_centi,
                                                             // [28:15] humidity_centi, rest 0
   output logic                                 rsp_tuser,  // [0] crc_ok
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [htfd_pkg::OFFSET_W-1:0]        csr_data
);

   logic [htfd_pkg::OFFSET_W-1:0] offset_ff;
   logic                          push, queue_full, pop, pop_valid;
   htfd_pkg::job_type             push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         offset_ff <= csr_data;
      end
   end

   htfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .byte_value  (req_tdata),
      .frame_start (req_tuser),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   htfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   htfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (pop_valid),
      .job         (pop_data),
      .job_pop     (pop),
      .temp_offset ($signed(offset_ff)),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
